// File: rtl/rbs_pkg.sv
// Shared constants, types and helpers for the ray/box slab intersection block.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package rbs_pkg;

  // Default formats: Q10.10 vector components, Q23.16 distances
  localparam int COMPONENT_BITS_DEF = 21;
  localparam int DISTANCE_BITS_DEF  = 40;
  localparam int DIST_FRAC          = 16;
  localparam int NUM_AXES           = 3;
  localparam int ID_W               = 32;
  localparam int FACE_W             = 3;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int PAR_TOL_W  = 10;
  localparam int IN_TOL_W   = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PAR_TOL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_TOL  = 2'd1;

  localparam logic [PAR_TOL_W-1:0] PAR_TOL_RST = 10'd1;
  localparam logic [IN_TOL_W-1:0]  IN_TOL_RST  = 16'd1;

  // Entry face codes
  localparam logic [FACE_W-1:0] FACE_NONE  = 3'd0;
  localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd1;
  localparam logic [FACE_W-1:0] FACE_POS_X = 3'd2;
  localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd3;
  localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd4;
  localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;
  localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd6;

  // Per-axis status handed from a lane to the merge stage
  typedef struct packed {
    logic par;      // direction component is zero
    logic par_out;  // origin outside the widened slab
    logic hi_near;  // high plane is the near one
  } lane_flags_t;

  // Lane latency: one prep stage, one stage per quotient bit, one select stage
  function automatic int lane_lat(input int cb);
    return cb + DIST_FRAC + 2;
  endfunction

  function automatic logic [FACE_W-1:0] face_code(input logic [1:0] axis,
                                                  input logic hi_near);
    logic [FACE_W-1:0] c;
    case (axis)
      2'd0:    c = hi_near ? FACE_POS_X : FACE_NEG_X;
      2'd1:    c = hi_near ? FACE_POS_Y : FACE_NEG_Y;
      2'd2:    c = hi_near ? FACE_POS_Z : FACE_NEG_Z;
      default: c = FACE_NONE;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/rbs_if.sv
// Valid/ready channel interfaces for query items and result items.
// Depends on rbs_pkg.
`timescale 1ns / 1ps

interface rbs_in_if import rbs_pkg::*; #(
  parameter int VEC_W = 3 * COMPONENT_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [VEC_W-1:0]       ray_origin;
  logic [VEC_W-1:0]       ray_direction;
  logic [VEC_W-1:0]       box_low_corner;
  logic [VEC_W-1:0]       box_high_corner;
  logic signed [ID_W-1:0] query_id;

  modport source (output valid, ray_origin, ray_direction, box_low_corner,
                  box_high_corner, query_id, input ready);
  modport sink (input valid, ray_origin, ray_direction, box_low_corner,
                box_high_corner, query_id, output ready);
endinterface

interface rbs_out_if import rbs_pkg::*; #(
  parameter int VEC_W  = 3 * COMPONENT_BITS_DEF,
  parameter int DIST_W = DISTANCE_BITS_DEF
) ();
  logic                     valid;
  logic                     ready;
  logic                     hit;
  logic signed [ID_W-1:0]   hit_id;
  logic signed [DIST_W-1:0] entry_distance;
  logic signed [DIST_W-1:0] exit_distance;
  logic [VEC_W-1:0]         hit_point;
  logic [FACE_W-1:0]        entry_face;

  modport source (output valid, hit, hit_id, entry_distance, exit_distance,
                  hit_point, entry_face, input ready);
  modport sink (input valid, hit, hit_id, entry_distance, exit_distance,
                hit_point, entry_face, output ready);
endinterface

// File: rtl/ray_box_slab_intersect_top.sv
// Ray versus axis-aligned box slab test, top level.
// Throughput: one item per cycle while the skid entry is empty; the three lanes
// each run two dividers pipelined at one quotient bit per stage
// (COMPONENT_BITS + 16 stages). Reset: synchronous, active low; clears all valid bits
// and loads both tolerance registers with 1. Depends on rbs_pkg, rbs_if, rbs_lane,
// rbs_merge.
`timescale 1ns / 1ps

module ray_box_slab_intersect_top import rbs_pkg::*; #(
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
  parameter int DISTANCE_BITS  = DISTANCE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rbs_in_if.sink                in_ch,
  rbs_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CB    = COMPONENT_BITS;
  localparam int DB    = DISTANCE_BITS;
  localparam int T_W   = CB + DIST_FRAC + 1;
  localparam int LAT   = lane_lat(CB);
  localparam int RES_W = 1 + ID_W + 2 * DB + 3 * CB + FACE_W;

  // Configuration registers
  logic [PAR_TOL_W-1:0] par_tol_r;
  logic [IN_TOL_W-1:0]  in_tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      par_tol_r <= PAR_TOL_RST;
      in_tol_r  <= IN_TOL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PAR_TOL: par_tol_r <= cfg_data[PAR_TOL_W-1:0];
        CFG_IN_TOL:  in_tol_r  <= cfg_data[IN_TOL_W-1:0];
        default:     ;
      endcase
    end
  end

  // Pipeline advances while the skid stage is empty
  logic skid_valid_r;
  logic en;

  assign en          = !skid_valid_r;
  assign in_ch.ready = en;

  // Valid and id travel beside the lanes
  logic                   v_r  [LAT];
  logic signed [ID_W-1:0] id_r [LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_ch.valid;
      for (int i = 1; i < LAT; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      id_r[0] <= in_ch.query_id;
      for (int i = 1; i < LAT; i++) id_r[i] <= id_r[i-1];
    end
  end

  // One lane per axis
  logic signed [T_W-1:0] tn [NUM_AXES];
  logic signed [T_W-1:0] tf [NUM_AXES];
  lane_flags_t           flags [NUM_AXES];
  logic signed [CB-1:0]  lo_o [NUM_AXES];
  logic signed [CB-1:0]  lo_d [NUM_AXES];

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    rbs_lane #(.CB(CB)) u_lane (
      .clk     (clk),
      .en      (en),
      .o       ($signed(in_ch.ray_origin[a*CB +: CB])),
      .d       ($signed(in_ch.ray_direction[a*CB +: CB])),
      .lo      ($signed(in_ch.box_low_corner[a*CB +: CB])),
      .hi      ($signed(in_ch.box_high_corner[a*CB +: CB])),
      .par_tol (par_tol_r),
      .tn      (tn[a]),
      .tf      (tf[a]),
      .flags   (flags[a]),
      .o_out   (lo_o[a]),
      .d_out   (lo_d[a])
    );
  end

  logic             res_valid;
  logic [RES_W-1:0] res;

  rbs_merge #(.CB(CB), .DB(DB)) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .valid_in  (v_r[LAT-1]),
    .id_in     (id_r[LAT-1]),
    .tn        (tn),
    .tf        (tf),
    .flags     (flags),
    .o         (lo_o),
    .d         (lo_d),
    .in_tol    (in_tol_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register with one skid entry
  logic             out_valid_r;
  logic [RES_W-1:0] out_r, skid_r;
  logic             take, incoming;

  assign take     = out_valid_r && out_ch.ready;
  assign incoming = en && res_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (incoming) begin
      if (out_valid_r && !take) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) out_r <= skid_r;
    end else if (incoming) begin
      if (out_valid_r && !take) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  // Unpack the result item
  assign out_ch.valid          = out_valid_r;
  assign out_ch.entry_face     = out_r[FACE_W-1:0];
  assign out_ch.hit_point      = out_r[FACE_W +: 3*CB];
  assign out_ch.exit_distance  = $signed(out_r[FACE_W + 3*CB +: DB]);
  assign out_ch.entry_distance = $signed(out_r[FACE_W + 3*CB + DB +: DB]);
  assign out_ch.hit_id         = $signed(out_r[FACE_W + 3*CB + 2*DB +: ID_W]);
  assign out_ch.hit            = out_r[RES_W-1];

endmodule

// File: rtl/rbs_div.sv
// Pipelined restoring divider on magnitudes: one quotient bit per stage.
// Depends on rbs_pkg. Carries side data alongside the quotient.
`timescale 1ns / 1ps

module rbs_div import rbs_pkg::*; #(
  parameter int NUM_W  = COMPONENT_BITS_DEF + DIST_FRAC,
  parameter int DEN_W  = COMPONENT_BITS_DEF,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              en,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic [NUM_W-1:0]  quot,
  output logic [SIDE_W-1:0] side_out
);

  logic [DEN_W-1:0]  rem_r  [NUM_W];
  logic [NUM_W-1:0]  nq_r   [NUM_W];
  logic [DEN_W-1:0]  den_r  [NUM_W];
  logic [SIDE_W-1:0] side_r [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [DEN_W-1:0]  rem_in;
    logic [NUM_W-1:0]  nq_in;
    logic [DEN_W-1:0]  den_in;
    logic [SIDE_W-1:0] side_k;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num;
      assign den_in = den;
      assign side_k = side_in;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign nq_in  = nq_r[k-1];
      assign den_in = den_r[k-1];
      assign side_k = side_r[k-1];
    end

    // Shift in the next dividend bit and try the subtract
    assign trial = {rem_in, nq_in[NUM_W-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = trial >= {1'b0, den_in};

    // Advance: dividend bits shift out at the top, quotient bits in at the bottom
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        nq_r[k]   <= {nq_in[NUM_W-2:0], ge};
        den_r[k]  <= den_in;
        side_r[k] <= side_k;
      end
    end
  end

  assign quot     = nq_r[NUM_W-1];
  assign side_out = side_r[NUM_W-1];

endmodule

// File: rtl/rbs_lane.sv
// One axis lane: parallel check, two plane-distance divisions, near/far select.
// Depends on rbs_pkg and rbs_div.
`timescale 1ns / 1ps

module rbs_lane import rbs_pkg::*; #(
  parameter int CB = COMPONENT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [CB-1:0]       o,
  input  logic signed [CB-1:0]       d,
  input  logic signed [CB-1:0]       lo,
  input  logic signed [CB-1:0]       hi,
  input  logic [PAR_TOL_W-1:0]       par_tol,
  output logic signed [CB+DIST_FRAC:0] tn,
  output logic signed [CB+DIST_FRAC:0] tf,
  output lane_flags_t                flags,
  output logic signed [CB-1:0]       o_out,
  output logic signed [CB-1:0]       d_out
);

  localparam int DIFF_W = CB + 1;
  localparam int MAG_W  = CB + DIST_FRAC;
  localparam int T_W    = MAG_W + 1;
  localparam int PCW    = ((CB > PAR_TOL_W) ? CB : PAR_TOL_W) + 2;
  localparam int SIDE_W = 3 + 2 * CB;

  // Prep: differences to the planes, magnitudes and signs
  logic signed [DIFF_W-1:0] dlo, dhi;
  logic [CB-1:0]            mlo, mhi, dmag;
  logic signed [PCW-1:0]    ow, lo_w, hi_w, tol_w;
  logic                     par, pout;

  assign dlo  = DIFF_W'(lo) - DIFF_W'(o);
  assign dhi  = DIFF_W'(hi) - DIFF_W'(o);
  assign mlo  = dlo[DIFF_W-1] ? CB'(-dlo) : CB'(dlo);
  assign mhi  = dhi[DIFF_W-1] ? CB'(-dhi) : CB'(dhi);
  assign dmag = d[CB-1] ? CB'(-d) : CB'(d);

  assign ow    = PCW'(o);
  assign lo_w  = PCW'(lo);
  assign hi_w  = PCW'(hi);
  assign tol_w = PCW'($signed({1'b0, par_tol}));
  assign par   = (d == '0);
  assign pout  = (ow < lo_w - tol_w) || (ow > hi_w + tol_w);

  logic [MAG_W-1:0]    n1_r, n2_r;
  logic [CB-1:0]       den_r;
  logic                s1_r, s2_r, par_r, pout_r;
  logic signed [CB-1:0] o_r, d_r;

  always_ff @(posedge clk) begin
    if (en) begin
      n1_r   <= {mlo, {DIST_FRAC{1'b0}}};
      n2_r   <= {mhi, {DIST_FRAC{1'b0}}};
      den_r  <= dmag;
      s1_r   <= dlo[DIFF_W-1] ^ d[CB-1];
      s2_r   <= dhi[DIFF_W-1] ^ d[CB-1];
      par_r  <= par;
      pout_r <= pout;
      o_r    <= o;
      d_r    <= d;
    end
  end

  // Low-plane and high-plane divisions
  logic [MAG_W-1:0]  q1, q2;
  logic              s1_q;
  logic [SIDE_W-1:0] side2_q;

  rbs_div #(.NUM_W(MAG_W), .DEN_W(CB), .SIDE_W(1)) u_div_lo (
    .clk      (clk),
    .en       (en),
    .num      (n1_r),
    .den      (den_r),
    .side_in  (s1_r),
    .quot     (q1),
    .side_out (s1_q)
  );

  rbs_div #(.NUM_W(MAG_W), .DEN_W(CB), .SIDE_W(SIDE_W)) u_div_hi (
    .clk      (clk),
    .en       (en),
    .num      (n2_r),
    .den      (den_r),
    .side_in  ({s2_r, par_r, pout_r, o_r, d_r}),
    .quot     (q2),
    .side_out (side2_q)
  );

  // Apply signs, order near and far
  logic signed [T_W-1:0] t1, t2, p1, p2;
  logic                  swap;

  assign p1   = $signed({1'b0, q1});
  assign p2   = $signed({1'b0, q2});
  assign t1   = s1_q ? -p1 : p1;
  assign t2   = side2_q[SIDE_W-1] ? -p2 : p2;
  assign swap = t1 > t2;

  always_ff @(posedge clk) begin
    if (en) begin
      tn            <= swap ? t2 : t1;
      tf            <= swap ? t1 : t2;
      flags.hi_near <= swap;
      flags.par     <= side2_q[SIDE_W-2];
      flags.par_out <= side2_q[SIDE_W-3];
      o_out         <= side2_q[2*CB-1:CB];
      d_out         <= side2_q[CB-1:0];
    end
  end

endmodule

// File: rtl/rbs_merge.sv
// Merge of the three lanes: entry/exit interval, hit decision, hit point.
// Depends on rbs_pkg. Two register stages, result presented from the last.
`timescale 1ns / 1ps

module rbs_merge import rbs_pkg::*; #(
  parameter int CB = COMPONENT_BITS_DEF,
  parameter int DB = DISTANCE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         valid_in,
  input  logic signed [ID_W-1:0]       id_in,
  input  logic signed [CB+DIST_FRAC:0] tn [NUM_AXES],
  input  logic signed [CB+DIST_FRAC:0] tf [NUM_AXES],
  input  lane_flags_t                  flags [NUM_AXES],
  input  logic signed [CB-1:0]         o [NUM_AXES],
  input  logic signed [CB-1:0]         d [NUM_AXES],
  input  logic [IN_TOL_W-1:0]          in_tol,
  output logic                         res_valid,
  output logic [1+ID_W+2*DB+3*CB+FACE_W-1:0] res
);

  localparam int T_W  = CB + DIST_FRAC + 1;
  localparam int TC_W = T_W + 1;
  localparam int CW   = (T_W > DB) ? T_W : DB;
  localparam int TL   = T_W / 2;
  localparam int TH   = T_W - TL;
  localparam int PR_W = CB + T_W;
  localparam int SW   = PR_W + 1;

  localparam logic signed [CW-1:0] DMAX = CW'($signed({1'b0, {(DB-1){1'b1}}}));
  localparam logic signed [CW-1:0] DMIN = CW'($signed({1'b1, {(DB-1){1'b0}}}));
  localparam logic signed [SW-1:0] PMAX = SW'($signed({1'b0, {(CB-1){1'b1}}}));
  localparam logic signed [SW-1:0] PMIN = SW'($signed({1'b1, {(CB-1){1'b0}}}));

  // Combine lanes in axis order: largest near, smallest far
  logic                  bnd, miss, orig_in;
  logic signed [T_W-1:0] te, tx, t_sel;
  logic [FACE_W-1:0]     fc;
  logic signed [TC_W-1:0] neg_tol;
  logic signed [CW-1:0]  te_x, tx_x, ent_sat, ext_sat;

  assign neg_tol = -TC_W'($signed({1'b0, in_tol}));

  always_comb begin
    bnd  = 1'b0;
    miss = 1'b0;
    te   = '0;
    tx   = '0;
    fc   = FACE_NONE;
    for (int a = 0; a < NUM_AXES; a++) begin
      if (flags[a].par) begin
        if (flags[a].par_out) miss = 1'b1;
      end else if (!bnd) begin
        bnd = 1'b1;
        te  = tn[a];
        tx  = tf[a];
        fc  = face_code(2'(a), flags[a].hi_near);
      end else begin
        if (tn[a] > te) begin
          te = tn[a];
          fc = face_code(2'(a), flags[a].hi_near);
        end
        if (tf[a] < tx) tx = tf[a];
      end
    end
    if (bnd && ((te > tx) || tx[T_W-1])) miss = 1'b1;
  end

  assign orig_in = !bnd || (TC_W'(te) <= neg_tol);
  assign t_sel   = orig_in ? '0 : te;
  assign te_x    = CW'(t_sel);
  assign tx_x    = CW'(tx);
  assign ent_sat = (te_x > DMAX) ? DMAX : ((te_x < DMIN) ? DMIN : te_x);
  assign ext_sat = !bnd ? DMAX : ((tx_x > DMAX) ? DMAX : ((tx_x < DMIN) ? DMIN : tx_x));

  // Stage M: interval result
  logic                  m_valid_r, m_hit_r;
  logic signed [ID_W-1:0] m_id_r;
  logic signed [T_W-1:0] m_t_r;
  logic [DB-1:0]         m_ent_r, m_ext_r;
  logic [FACE_W-1:0]     m_face_r;
  logic signed [CB-1:0]  m_o_r [NUM_AXES];
  logic signed [CB-1:0]  m_d_r [NUM_AXES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else if (en) begin
      m_valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_hit_r  <= !miss;
      m_id_r   <= id_in;
      m_t_r    <= t_sel;
      m_ent_r  <= ent_sat[DB-1:0];
      m_ext_r  <= ext_sat[DB-1:0];
      m_face_r <= orig_in ? FACE_NONE : fc;
      m_o_r    <= o;
      m_d_r    <= d;
    end
  end

  // Stage P: direction times t as two partial products per axis
  logic signed [CB+TL:0]   pl [NUM_AXES];
  logic signed [CB+TH-1:0] ph [NUM_AXES];

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_mul
    assign pl[a] = m_d_r[a] * $signed({1'b0, m_t_r[TL-1:0]});
    assign ph[a] = m_d_r[a] * $signed(m_t_r[T_W-1:TL]);
  end

  logic                   p_valid_r, p_hit_r;
  logic signed [ID_W-1:0] p_id_r;
  logic [DB-1:0]          p_ent_r, p_ext_r;
  logic [FACE_W-1:0]      p_face_r;
  logic signed [CB-1:0]   p_o_r  [NUM_AXES];
  logic signed [CB+TL:0]  p_pl_r [NUM_AXES];
  logic signed [CB+TH-1:0] p_ph_r [NUM_AXES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (en) begin
      p_valid_r <= m_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_hit_r  <= m_hit_r;
      p_id_r   <= m_id_r;
      p_ent_r  <= m_ent_r;
      p_ext_r  <= m_ext_r;
      p_face_r <= m_face_r;
      p_o_r    <= m_o_r;
      p_pl_r   <= pl;
      p_ph_r   <= ph;
    end
  end

  // Recombine, floor to Q10.10, add origin and saturate
  logic [3*CB-1:0] point;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_pt
    logic signed [PR_W-1:0] prod;
    logic signed [PR_W-1:0] shf;
    logic signed [SW-1:0]   sum;
    logic signed [SW-1:0]   sat;

    assign prod = (PR_W'(p_ph_r[a]) <<< TL) + PR_W'(p_pl_r[a]);
    assign shf  = prod >>> DIST_FRAC;
    assign sum  = SW'(p_o_r[a]) + SW'(shf);
    assign sat  = (sum > PMAX) ? PMAX : ((sum < PMIN) ? PMIN : sum);
    assign point[a*CB +: CB] = sat[CB-1:0];
  end

  // Drop every field on a miss
  assign res_valid = p_valid_r;
  assign res = p_hit_r ? {1'b1, p_id_r, p_ent_r, p_ext_r, point, p_face_r} : '0;

endmodule

// File: tb/testbench.sv
// Self-checking bench for ray_box_slab_intersect_top: directed table, then random rays.
// Depends on rbs_pkg, rbs_if and the block's RTL; carries its own slab-test predictor.
`timescale 1ns / 1ps

module testbench;
  import rbs_pkg::*;

  localparam int CB = COMPONENT_BITS_DEF;
  localparam int DB = DISTANCE_BITS_DEF;
  localparam int VW = 3 * CB;
  localparam longint DIST_MAX = (longint'(1) <<< (DB - 1)) - 1;
  localparam longint DIST_MIN = -DIST_MAX - 1;
  localparam longint COMP_MAX = (longint'(1) <<< (CB - 1)) - 1;
  localparam longint COMP_MIN = -COMP_MAX - 1;
  localparam int SETTLE = 2 * (COMPONENT_BITS_DEF + 21) + 10;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1500;

  // Faces entered through the low and high plane of each axis
  localparam logic [FACE_W-1:0] LOW_FACE[3]  = '{FACE_NEG_X, FACE_NEG_Y, FACE_NEG_Z};
  localparam logic [FACE_W-1:0] HIGH_FACE[3] = '{FACE_POS_X, FACE_POS_Y, FACE_POS_Z};

  typedef struct {
    logic [VW-1:0]          origin;
    logic [VW-1:0]          direction;
    logic [VW-1:0]          box_lo;
    logic [VW-1:0]          box_hi;
    logic signed [ID_W-1:0] id;
  } query_t;

  typedef struct {
    logic                   hit;
    logic signed [ID_W-1:0] hit_id;
    logic signed [DB-1:0]   t_in;
    logic signed [DB-1:0]   t_out;
    logic [VW-1:0]          point;
    logic [FACE_W-1:0]      face;
  } slab_result_t;

  typedef struct {
    query_t       q;
    logic         typed;
    slab_result_t res;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rbs_in_if  in_ch ();
  rbs_out_if out_ch ();

  ray_box_slab_intersect_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor copy of the two tolerance registers
  longint par_tol;
  longint in_tol;

  slab_result_t pending_hits[$];
  int errors;
  int checked;
  int hit_count;
  int cycles;
  stim_row_t rows[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [VW-1:0] vec(longint x, longint y, longint z);
    logic [CB-1:0] a, b, c;
    a = x[CB-1:0];
    b = y[CB-1:0];
    c = z[CB-1:0];
    return {c, b, a};
  endfunction

  function automatic longint comp(logic [VW-1:0] v, int axis);
    logic signed [CB-1:0] c;
    longint r;
    c = v[axis*CB +: CB];
    r = c;
    return r;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Slab test: per-axis plane distances, largest near, smallest far
  function automatic slab_result_t slab_predict(query_t q);
    slab_result_t r;
    logic bounded;
    longint t_near, t_far, t, o, d, lo, hi, t1, t2, tn, tf, p;
    logic [FACE_W-1:0] face, nf;
    r = '{default: '0};
    bounded = 1'b0;
    t_near = 0;
    t_far = 0;
    face = FACE_NONE;
    for (int a = 0; a < 3; a++) begin
      o = comp(q.origin, a);
      d = comp(q.direction, a);
      lo = comp(q.box_lo, a);
      hi = comp(q.box_hi, a);
      if (d == 0) begin
        if (o < lo - par_tol || o > hi + par_tol) return r;
        continue;
      end
      t1 = ((lo - o) * 65536) / d;
      t2 = ((hi - o) * 65536) / d;
      tn = t1;
      tf = t2;
      nf = LOW_FACE[a];
      if (t1 > t2) begin
        tn = t2;
        tf = t1;
        nf = HIGH_FACE[a];
      end
      if (!bounded) begin
        bounded = 1'b1;
        t_near = tn;
        t_far = tf;
        face = nf;
      end else begin
        if (tn > t_near) begin
          t_near = tn;
          face = nf;
        end
        if (tf < t_far) t_far = tf;
      end
    end
    if (bounded && (t_near > t_far || t_far < 0)) return r;
    if (!bounded || t_near <= -in_tol) begin
      t = 0;
      face = FACE_NONE;
    end else begin
      t = t_near;
    end
    for (int a = 0; a < 3; a++) begin
      p = clamp(comp(q.origin, a) + ((comp(q.direction, a) * t) >>> DIST_FRAC),
                COMP_MIN, COMP_MAX);
      r.point[a*CB +: CB] = p[CB-1:0];
    end
    r.hit = 1'b1;
    r.hit_id = q.id;
    r.t_in = DB'(clamp(t, DIST_MIN, DIST_MAX));
    r.t_out = bounded ? DB'(clamp(t_far, DIST_MIN, DIST_MAX)) : DB'(DIST_MAX);
    r.face = face;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("MISMATCH result %0d %s: got %h want %h", checked, what, got, want);
  endtask

  // Result side: check each accepted result, and stall on a pattern that rotates through four modes
  always @(posedge clk) begin
    slab_result_t e;
    int mode;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_hits.size() == 0) begin
          report_mismatch("unexpected result", 64'(out_ch.hit), 64'd0);
        end else begin
          e = pending_hits.pop_front();
          if (out_ch.hit !== e.hit) report_mismatch("hit", out_ch.hit, e.hit);
          if (out_ch.hit_id !== e.hit_id) report_mismatch("hit_id", out_ch.hit_id, e.hit_id);
          if (out_ch.entry_distance !== e.t_in)
            report_mismatch("entry_distance", out_ch.entry_distance, e.t_in);
          if (out_ch.exit_distance !== e.t_out)
            report_mismatch("exit_distance", out_ch.exit_distance, e.t_out);
          if (out_ch.hit_point !== e.point)
            report_mismatch("hit_point", out_ch.hit_point, e.point);
          if (out_ch.entry_face !== e.face)
            report_mismatch("entry_face", out_ch.entry_face, e.face);
          if (e.hit) hit_count++;
          checked++;
        end
      end
      mode = (cycles / 300) % 4;
      case (mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(99) < 70);
        2: out_ch.ready <= ((cycles % 7) < 2);
        default: out_ch.ready <= ($urandom_range(99) < 15);
      endcase
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // Present one item and hold it until accepted; leaves valid high
  task automatic send_query(query_t q, logic typed, slab_result_t want);
    in_ch.valid <= 1'b1;
    in_ch.ray_origin <= q.origin;
    in_ch.ray_direction <= q.direction;
    in_ch.box_low_corner <= q.box_lo;
    in_ch.box_high_corner <= q.box_hi;
    in_ch.query_id <= q.id;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_hits.push_back(typed ? want : slab_predict(q));
  endtask

  task automatic idle_gap(int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Drain, let the pipeline settle, then write both registers
  task automatic set_tolerances(longint par, longint ins);
    in_ch.valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_PAR_TOL;
    cfg_data <= par[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= CFG_IN_TOL;
    cfg_data <= ins[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    par_tol = par & 10'h3FF;
    in_tol = ins & 16'hFFFF;
  endtask

  function automatic longint rnd(longint lo, longint hi);
    return lo + longint'($urandom_range(int'(hi - lo)));
  endfunction

  function automatic logic [VW-1:0] noise_vec();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[VW-1:0];
  endfunction

  // Ray aimed at a point inside a random box, with random distortions
  function automatic query_t aimed_query();
    query_t q;
    longint lo[3], hi[3], o[3], d[3], tgt;
    int shift;
    int kind;
    kind = $urandom_range(99);
    shift = $urandom_range(4);
    for (int a = 0; a < 3; a++) begin
      lo[a] = rnd(-(1 << 18), 1 << 18);
      hi[a] = lo[a] + rnd(0, 1 << ($urandom_range(16)));
      tgt = rnd(lo[a], hi[a]);
      o[a] = ($urandom_range(3) == 0) ? tgt : rnd(-(1 << 19), 1 << 19);
      d[a] = (tgt - o[a]) >>> shift;
      if ($urandom_range(7) == 0) d[a] = 0;
      if (kind < 10) d[a] = -d[a];
      if (kind >= 10 && kind < 15) begin
        tgt = lo[a];
        lo[a] = hi[a];
        hi[a] = tgt;
      end
    end
    q.origin = vec(o[0], o[1], o[2]);
    q.direction = vec(d[0], d[1], d[2]);
    q.box_lo = vec(lo[0], lo[1], lo[2]);
    q.box_hi = vec(hi[0], hi[1], hi[2]);
    q.id = $urandom;
    if (kind >= 90) begin
      q.origin = noise_vec();
      q.direction = noise_vec();
      q.box_lo = noise_vec();
      q.box_hi = noise_vec();
    end
    return q;
  endfunction

  function automatic stim_row_t row(logic [VW-1:0] o, logic [VW-1:0] d, logic [VW-1:0] lo,
                                    logic [VW-1:0] hi, int id, logic typed,
                                    slab_result_t res);
    stim_row_t r;
    r.q = '{o, d, lo, hi, id};
    r.typed = typed;
    r.res = res;
    return r;
  endfunction

  initial begin
    slab_result_t miss, none;
    slab_result_t open_hit;
    query_t q;
    int burst;
    logic [VW-1:0] unit_lo, unit_hi;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_PAR_TOL;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.ray_origin = '0;
    in_ch.ray_direction = '0;
    in_ch.box_low_corner = '0;
    in_ch.box_high_corner = '0;
    in_ch.query_id = '0;
    par_tol = 1;
    in_tol = 1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    miss = '{default: '0};
    none = '{default: '0};
    unit_lo = vec(0, 0, 0);
    unit_hi = vec(1024, 1024, 1024);

    // Parallel ray outside the widened slab: miss with all fields zero
    rows.push_back(row(vec(100 << 10, 5, 5), vec(0, 1024, 0), unit_lo, unit_hi, 7, 1'b1,
                       miss));
    // No axis bounds t: hit at the origin, exit saturated
    open_hit = '{1'b1, 32'sd11, '0, DB'(DIST_MAX), vec(512, 512, 512), FACE_NONE};
    rows.push_back(row(vec(512, 512, 512), vec(0, 0, 0), unit_lo, unit_hi, 11, 1'b1,
                       open_hit));
    // Parallel origin just inside the tolerance band
    open_hit = '{1'b1, 32'sd12, '0, DB'(DIST_MAX), vec(1025, -1, 0), FACE_NONE};
    rows.push_back(row(vec(1025, -1, 0), vec(0, 0, 0), unit_lo, unit_hi, 12, 1'b1,
                       open_hit));
    // Parallel origin one step beyond the tolerance band
    rows.push_back(row(vec(1026, 0, 0), vec(0, 0, 0), unit_lo, unit_hi, 13, 1'b1, miss));
    // Entry through each face
    rows.push_back(row(vec(-4096, 512, 512), vec(1024, 0, 0), unit_lo, unit_hi, 20, 1'b0, none));
    rows.push_back(row(vec(4096, 512, 512), vec(-1024, 0, 0), unit_lo, unit_hi, 21, 1'b0, none));
    rows.push_back(row(vec(512, -4096, 512), vec(0, 1024, 0), unit_lo, unit_hi, 22, 1'b0, none));
    rows.push_back(row(vec(512, 4096, 512), vec(0, -1024, 0), unit_lo, unit_hi, 23, 1'b0, none));
    rows.push_back(row(vec(512, 512, -4096), vec(0, 0, 1024), unit_lo, unit_hi, 24, 1'b0, none));
    rows.push_back(row(vec(512, 512, 4096), vec(0, 0, -1024), unit_lo, unit_hi, 25, 1'b0, none));
    // Origin inside, origin on the low plane, box behind the ray
    rows.push_back(row(vec(512, 512, 512), vec(300, -200, 100), unit_lo, unit_hi, 30, 1'b0,
                       none));
    rows.push_back(row(vec(0, 512, 512), vec(1024, 0, 0), unit_lo, unit_hi, 31, 1'b0, none));
    rows.push_back(row(vec(4096, 512, 512), vec(1024, 0, 0), unit_lo, unit_hi, 32, 1'b0, none));
    // Flat box on x, diagonal tie across axes, inverted box
    rows.push_back(row(vec(-2048, 512, 512), vec(1024, 0, 0), vec(0, 0, 0),
                       vec(0, 1024, 1024), 33, 1'b0, none));
    rows.push_back(row(vec(-1024, -1024, -1024), vec(1024, 1024, 1024), unit_lo, unit_hi,
                       34, 1'b0, none));
    rows.push_back(row(vec(-4096, 512, 512), vec(1024, 0, 0), unit_hi, unit_lo, 35, 1'b0,
                       none));
    // Component extremes and id extremes
    rows.push_back(row(vec(COMP_MIN, COMP_MIN, COMP_MIN), vec(1, 1, 1),
                       vec(COMP_MAX, COMP_MAX, COMP_MAX), vec(COMP_MAX, COMP_MAX, COMP_MAX),
                       32'h7FFF_FFFF, 1'b0, none));
    rows.push_back(row(vec(COMP_MAX, COMP_MAX, COMP_MAX), vec(COMP_MIN, COMP_MIN, COMP_MIN),
                       vec(COMP_MIN, COMP_MIN, COMP_MIN), vec(COMP_MAX, COMP_MAX, COMP_MAX),
                       32'h8000_0000, 1'b0, none));
    rows.push_back(row(vec(COMP_MIN, 0, COMP_MAX), vec(-1, COMP_MAX, 1),
                       vec(COMP_MIN, COMP_MIN, COMP_MIN), vec(COMP_MAX, COMP_MAX, COMP_MAX),
                       -1, 1'b0, none));

    // Walk the directed table at default tolerances, back to back
    foreach (rows[i]) send_query(rows[i].q, rows[i].typed, rows[i].res);
    idle_gap(1);

    // Random phases under several tolerance settings, extremes included
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_tolerances(0, 0);
        1: set_tolerances(1023, 65535);
        2: set_tolerances($urandom_range(1023), $urandom_range(65535));
        3: set_tolerances(1, 1);
        default: set_tolerances($urandom_range(1023), 65535);
      endcase
      // Re-run the directed geometry under the new setting
      foreach (rows[i]) send_query(rows[i].q, 1'b0, none);
      for (int n = 0; n < RANDOM_ITEMS / 5; ) begin
        burst = $urandom_range(40, 1);
        for (int k = 0; k < burst && n < RANDOM_ITEMS / 5; k++, n++) begin
          q = aimed_query();
          send_query(q, 1'b0, none);
        end
        if ($urandom_range(3) != 0) idle_gap($urandom_range(6, 1));
      end
      idle_gap(1);
    end

    while (pending_hits.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("Checked %0d results (%0d hits) over five tolerance settings,", checked, hit_count);
    $display("with directed faces, ties, parallel cases and random aimed rays.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
